// File: sv/pdisp_pkg.sv
// Shared types, codes and defaults for the periodic task dispatcher.
`default_nettype none
package pdisp_pkg;

   localparam int TASK_SLOTS_DEF = 8;
   localparam int COUNT_BITS_DEF = 16;

   localparam int CMD_W    = 2;
   localparam int INDEX_W  = 3;
   localparam int FIELD_W  = 16;
   localparam int STATUS_W = 2;
   localparam int MASK_W   = 8;

   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 16;

   typedef enum logic [CMD_W-1:0] {
      CMD_ADD    = 2'd0,
      CMD_STOP   = 2'd1,
      CMD_DELETE = 2'd2,
      CMD_TICK   = 2'd3
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

endpackage
`default_nettype wire

// File: sv/pdisp_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module pdisp_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8,
   localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic                 clock,
   input  wire logic                 wr_en,
   input  wire logic [ADDR_BITS-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]     wr_data,
   input  wire logic                 rd_en,
   input  wire logic [ADDR_BITS-1:0] rd_addr,
   output logic      [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule
`default_nettype wire

// File: sv/periodic_task_dispatcher.sv
// Periodic task dispatcher: slot table with a sequencer walking one slot RAM.
// Add and stop go straight to the done state, which registers their result.
// Tick reads and rewrites each running slot and steps over the other slots;
// delete moves each slot above the deleted one down by one place.
// The block takes one beat at a time; the result register frees it early.
// Reset clears the flags and the task count; the slot RAM is not cleared.
`default_nettype none
module periodic_task_dispatcher #(
   parameter int TASK_SLOTS = pdisp_pkg::TASK_SLOTS_DEF,
   parameter int COUNT_BITS = pdisp_pkg::COUNT_BITS_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   // task_index, period, first_delay, start_running, zero fill
   input  wire logic [pdisp_pkg::REQ_DATA_W-1:0] req_tdata,
   // command
   input  wire logic [pdisp_pkg::CMD_W-1:0]      req_tuser,
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   // status, assigned_index, fire_mask, zero fill
   output logic      [pdisp_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   localparam int IDX_BITS = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
   localparam int CNT_W    = $clog2(TASK_SLOTS + 1);
   localparam int ENTRY_W  = 2 * COUNT_BITS;

   typedef enum logic [2:0] {
      S_IDLE,
      S_TICK_RD,
      S_TICK_WR,
      S_DEL_RD,
      S_DEL_WR,
      S_DONE
   } state_type;

   state_type                         state_ff, state_in;
   logic [CNT_W-1:0]                  count_ff, count_in;
   logic [CNT_W-1:0]                  ptr_ff, ptr_in;
   logic [TASK_SLOTS-1:0]             valid_ff, valid_in;
   logic [TASK_SLOTS-1:0]             running_ff, running_in;
   logic [pdisp_pkg::STATUS_W-1:0]    status_ff, status_in;
   logic [pdisp_pkg::INDEX_W-1:0]     assigned_ff, assigned_in;
   logic [pdisp_pkg::MASK_W-1:0]      fire_ff, fire_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [pdisp_pkg::RSP_DATA_W-1:0]  rsp_data_ff, rsp_data_in;

   pdisp_pkg::cmd_type                req_cmd;
   logic [pdisp_pkg::INDEX_W-1:0]     req_index;
   logic [pdisp_pkg::FIELD_W-1:0]     req_period;
   logic [pdisp_pkg::FIELD_W-1:0]     req_delay;
   logic                              req_run;
   logic [IDX_BITS-1:0]               idx_ext;
   logic                              idx_usable;
   logic [TASK_SLOTS-1:0]             low_mask;
   logic                              ptr_last;
   logic                              slot_active;

   logic                              ram_wr_en;
   logic [IDX_BITS-1:0]               ram_wr_addr;
   logic [ENTRY_W-1:0]                ram_wr_data;
   logic                              ram_rd_en;
   logic [IDX_BITS-1:0]               ram_rd_addr;
   logic [ENTRY_W-1:0]                ram_rd_data;
   logic [COUNT_BITS-1:0]             rd_period;
   logic [COUNT_BITS-1:0]             rd_count;
   logic [COUNT_BITS-1:0]             new_count;

   assign req_cmd    = pdisp_pkg::cmd_type'(req_tuser);
   assign req_index  = req_tdata[2:0];
   assign req_period = req_tdata[18:3];
   assign req_delay  = req_tdata[34:19];
   assign req_run    = req_tdata[35];

   assign idx_ext    = IDX_BITS'(req_index);
   assign idx_usable = (32'(req_index) < 32'(TASK_SLOTS)) && valid_ff[idx_ext];
   assign low_mask   = (TASK_SLOTS'(1) << idx_ext) - TASK_SLOTS'(1);

   assign ptr_last    = (ptr_ff == CNT_W'(TASK_SLOTS - 1));
   assign slot_active = valid_ff[ptr_ff[IDX_BITS-1:0]] && running_ff[ptr_ff[IDX_BITS-1:0]];

   assign rd_period = ram_rd_data[ENTRY_W-1:COUNT_BITS];
   assign rd_count  = ram_rd_data[COUNT_BITS-1:0];
   assign new_count = ((rd_count == '0) ? rd_period : rd_count) - COUNT_BITS'(1);

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   pdisp_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TASK_SLOTS)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      ptr_in       = ptr_ff;
      valid_in     = valid_ff;
      running_in   = running_ff;
      status_in    = status_ff;
      assigned_in  = assigned_ff;
      fire_in      = fire_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = ptr_ff[IDX_BITS-1:0];
      ram_wr_data  = {rd_period, new_count};
      ram_rd_en    = 1'b0;
      ram_rd_addr  = ptr_ff[IDX_BITS-1:0];

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               status_in   = pdisp_pkg::ST_OK;
               assigned_in = '0;
               fire_in     = '0;
               ptr_in      = '0;
               state_in    = S_DONE;
               case (req_cmd)
                  pdisp_pkg::CMD_ADD: begin
                     if (32'(count_ff) >= 32'(TASK_SLOTS)) begin
                        status_in = pdisp_pkg::ST_FULL;
                     end else begin
                        ram_wr_en   = 1'b1;
                        ram_wr_addr = count_ff[IDX_BITS-1:0];
                        ram_wr_data = {COUNT_BITS'(req_period), COUNT_BITS'(req_delay)};
                        valid_in[count_ff[IDX_BITS-1:0]]   = 1'b1;
                        running_in[count_ff[IDX_BITS-1:0]] = req_run;
                        count_in    = count_ff + CNT_W'(1);
                        assigned_in = pdisp_pkg::INDEX_W'(count_ff);
                     end
                  end
                  pdisp_pkg::CMD_STOP: begin
                     if (!idx_usable) begin
                        status_in = pdisp_pkg::ST_EMPTY;
                     end else begin
                        running_in[idx_ext] = 1'b0;
                     end
                  end
                  pdisp_pkg::CMD_DELETE: begin
                     if (!idx_usable) begin
                        status_in = pdisp_pkg::ST_EMPTY;
                     end else begin
                        valid_in   = (valid_ff & low_mask) | ((valid_ff >> 1) & ~low_mask);
                        running_in = (running_ff & low_mask) | ((running_ff >> 1) & ~low_mask);
                        count_in   = count_ff - CNT_W'(1);
                        ptr_in     = CNT_W'(idx_ext) + CNT_W'(1);
                        if (32'(req_index) + 32'd1 < 32'(TASK_SLOTS)) begin
                           state_in = S_DEL_RD;
                        end
                     end
                  end
                  pdisp_pkg::CMD_TICK: begin
                     state_in = S_TICK_RD;
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end
         S_TICK_RD: begin
            if (slot_active) begin
               ram_rd_en = 1'b1;
               state_in  = S_TICK_WR;
            end else if (ptr_last) begin
               state_in = S_DONE;
            end else begin
               ptr_in = ptr_ff + CNT_W'(1);
            end
         end
         S_TICK_WR: begin
            ram_wr_en = 1'b1;
            if (rd_count == '0) begin
               fire_in = fire_ff | (pdisp_pkg::MASK_W'(1) << ptr_ff);
            end
            if (ptr_last) begin
               state_in = S_DONE;
            end else begin
               ptr_in   = ptr_ff + CNT_W'(1);
               state_in = S_TICK_RD;
            end
         end
         S_DEL_RD: begin
            ram_rd_en = 1'b1;
            state_in  = S_DEL_WR;
         end
         S_DEL_WR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = IDX_BITS'(ptr_ff - CNT_W'(1));
            ram_wr_data = ram_rd_data;
            if (ptr_last) begin
               state_in = S_DONE;
            end else begin
               ptr_in   = ptr_ff + CNT_W'(1);
               state_in = S_DEL_RD;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = pdisp_pkg::RSP_DATA_W'({fire_ff, assigned_ff, status_ff});
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         ptr_ff       <= '0;
         valid_ff     <= '0;
         running_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         ptr_ff       <= ptr_in;
         valid_ff     <= valid_in;
         running_ff   <= running_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      status_ff   <= status_in;
      assigned_ff <= assigned_in;
      fire_ff     <= fire_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule
`default_nettype wire
